// File: rtl/bfeu_pkg.sv
// Shared types and constants for the Brainfuck execute unit.
// No dependencies; imported by bfeu_exec and the top level (bfeu_ram does not use it).
package bfeu_pkg;

  localparam int IP_W     = 13;
  localparam int CP_W     = 16;
  localparam int OP_W     = 3;
  localparam int TARGET_W = 12;
  localparam int CHAR_W   = 8;
  localparam int END_W    = 17;

  localparam int CELL_COUNT_DEF    = 1024;
  localparam int PROGRAM_DEPTH_DEF = 4096;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_PTR_INC = 3'd0,
    OP_PTR_DEC = 3'd1,
    OP_VAL_INC = 3'd2,
    OP_VAL_DEC = 3'd3,
    OP_OUTPUT  = 3'd4,
    OP_READ    = 3'd5,
    OP_JUMP    = 3'd6,
    OP_JNZ     = 3'd7
  } op_t;

  // Result of one instruction as seen by the consumer.
  typedef struct packed {
    logic [IP_W-1:0]   next_ptr;
    logic [CHAR_W-1:0] out_char;
    logic              out_valid;
    logic              in_taken;
    logic              halted;
  } exec_res_t;

  // State update for the cell side.
  typedef struct packed {
    logic [CP_W-1:0]   cp_next;
    logic [CHAR_W-1:0] cell_next;
    logic              cell_we;
    logic              cell_ok;
    logic              moved;
    logic              running;
  } cell_upd_t;

endpackage

// File: rtl/bfeu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfeu_exec.sv
// Combinational execute step: decodes one instruction against the current state.
// Depends on bfeu_pkg.
module bfeu_exec #(
  parameter int CELL_COUNT    = bfeu_pkg::CELL_COUNT_DEF,
  parameter int PROGRAM_DEPTH = bfeu_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic [bfeu_pkg::OP_W-1:0]     operation,
  input  logic [bfeu_pkg::TARGET_W-1:0] jump_target,
  input  logic [bfeu_pkg::CHAR_W-1:0]   input_char,
  input  logic [bfeu_pkg::IP_W-1:0]     ip,
  input  logic [bfeu_pkg::CP_W-1:0]     cp,
  input  logic [bfeu_pkg::CHAR_W-1:0]   cur_cell,
  input  logic [bfeu_pkg::IP_W-1:0]     prog_len,
  output bfeu_pkg::exec_res_t           res,
  output bfeu_pkg::cell_upd_t           upd
);
  import bfeu_pkg::*;

  localparam logic [END_W-1:0] DEPTH_L = END_W'(PROGRAM_DEPTH);
  localparam logic [END_W-1:0] CELLS_L = END_W'(CELL_COUNT);

  logic [END_W-1:0] len_ext;
  logic [END_W-1:0] prog_end;
  logic [IP_W-1:0]  nxt;
  logic             run;
  logic             ok;
  op_t              op;

  assign len_ext  = END_W'(prog_len);
  assign prog_end = (len_ext > DEPTH_L) ? DEPTH_L : len_ext;
  assign run      = END_W'(ip) < prog_end;
  // negative pointers have bit 15 set and fail this compare too
  assign ok       = END_W'(cp) < CELLS_L;
  assign op       = op_t'(operation);

  always_comb begin
    nxt           = ip + IP_W'(1);
    upd.cp_next   = cp;
    upd.cell_next = cur_cell;
    upd.cell_we   = 1'b0;
    upd.moved     = 1'b0;
    res.out_char  = '0;
    res.out_valid = 1'b0;
    res.in_taken  = 1'b0;
    unique case (op)
      OP_PTR_INC: begin
        upd.cp_next = cp + CP_W'(1);
        upd.moved   = 1'b1;
      end
      OP_PTR_DEC: begin
        upd.cp_next = cp - CP_W'(1);
        upd.moved   = 1'b1;
      end
      OP_VAL_INC: begin
        upd.cell_next = cur_cell + CHAR_W'(1);
        upd.cell_we   = ok;
      end
      OP_VAL_DEC: begin
        upd.cell_next = cur_cell - CHAR_W'(1);
        upd.cell_we   = ok;
      end
      OP_OUTPUT: begin
        res.out_char  = ok ? cur_cell : '0;
        res.out_valid = ok;
      end
      OP_READ: begin
        upd.cell_next = input_char;
        upd.cell_we   = ok;
        res.in_taken  = ok;
      end
      OP_JUMP: begin
        nxt = IP_W'(jump_target);
      end
      OP_JNZ: begin
        if (ok && (cur_cell != '0)) begin
          nxt = IP_W'(jump_target);
        end
      end
      default: begin
      end
    endcase
    // a halted machine ignores the instruction entirely
    if (!run) begin
      nxt           = ip;
      upd.cp_next   = cp;
      upd.cell_next = cur_cell;
      upd.cell_we   = 1'b0;
      upd.moved     = 1'b0;
      res.out_char  = '0;
      res.out_valid = 1'b0;
      res.in_taken  = 1'b0;
    end
    res.next_ptr = nxt;
    res.halted   = END_W'(nxt) >= prog_end;
    upd.cell_ok  = ok;
    upd.running  = run;
  end

endmodule

// File: rtl/brainfuck_execute_unit_top.sv
// Top level of the Brainfuck execute unit: state registers, cell RAM, output register.
// Depends on bfeu_pkg, bfeu_ram and bfeu_exec.

// One instruction is accepted per clock on the s_ side while s_tready is high, and
// its single result is registered in the m_ output register; a new instruction is
// taken in the same cycle that a waiting result is transferred, so with m_tready
// held high the sustained rate is one instruction per cycle. The current cell is
// kept in a register and forwarded, so back-to-back read-modify-writes of one cell
// need no stall; after a pointer move the cell comes from the RAM's registered read
// port. After reset the cell RAM is cleared one cell per cycle, with s_tready held
// low; the program_length register (cfg_) is always ready and should be written
// only while no instruction is in flight.
module brainfuck_execute_unit_top #(
  parameter int CELL_COUNT    = bfeu_pkg::CELL_COUNT_DEF,
  parameter int PROGRAM_DEPTH = bfeu_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfeu_pkg::IP_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operation[2:0], jump_target[14:3], input_char[22:15], zero[23]
  input  logic [bfeu_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // next_pointer[12:0], output_char[20:13], output_valid[21], input_taken[22],
  // halted[23]
  output logic [bfeu_pkg::M_DATA_W-1:0] m_tdata
);
  import bfeu_pkg::*;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  logic [IP_W-1:0]   prog_len;
  logic [IP_W-1:0]   ip;
  logic [CP_W-1:0]   cp;
  logic [CP_W-1:0]   cp_next;
  logic [CHAR_W-1:0] cell_hold;
  logic [CHAR_W-1:0] cur_cell;
  logic [CHAR_W-1:0] rdata;
  logic              ptr_moved;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              acc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  exec_res_t         res;
  cell_upd_t         upd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !clearing && (!m_tvalid || m_tready);
  assign acc       = s_tvalid && s_tready;

  // right after a pointer move the RAM output holds the new cell
  assign cur_cell  = ptr_moved ? rdata : cell_hold;
  assign cp_next   = acc ? upd.cp_next : cp;

  bfeu_exec #(
    .CELL_COUNT    (CELL_COUNT),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_exec (
    .operation   (s_tdata[2:0]),
    .jump_target (s_tdata[14:3]),
    .input_char  (s_tdata[22:15]),
    .ip          (ip),
    .cp          (cp),
    .cur_cell    (cur_cell),
    .prog_len    (prog_len),
    .res         (res),
    .upd         (upd)
  );

  assign ram_we    = clearing || (acc && upd.cell_we);
  assign ram_waddr = clearing ? clr_addr : cp[ADDR_W-1:0];
  assign ram_wdata = clearing ? '0 : upd.cell_next;

  bfeu_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cp_next[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len  <= '0;
      ip        <= '0;
      cp        <= '0;
      cell_hold <= '0;
      ptr_moved <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prog_len <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end
      ptr_moved <= acc && upd.moved;
      cell_hold <= (acc && upd.cell_we) ? upd.cell_next : cur_cell;
      if (acc) begin
        ip <= res.next_ptr;
        cp <= upd.cp_next;
      end
      if (acc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_tdata <= {res.halted, res.in_taken, res.out_valid, res.out_char, res.next_ptr};
    end
  end

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("instruction accepted during cell clear");

  a_moved_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    ptr_moved |-> $past(acc))
    else $error("pointer move flag without an instruction transfer");

  a_halted_keeps_ip: assert property (@(posedge clk) disable iff (rst)
    (acc && !upd.running) |=> (ip == $past(ip)) && (cp == $past(cp)))
    else $error("halted machine changed its pointers");

  a_write_only_valid_cell: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (clearing || upd.cell_ok))
    else $error("cell write with pointer outside the store");
`endif

endmodule
